// File: design/lcm_pkg.sv
// Package for the link connection manager core.
// Holds opcodes, frame kinds, protocol constants; no dependencies.
package lcm_pkg;

   localparam logic [2:0] OP_RX_FRAME = 3'd0;
   localparam logic [2:0] OP_TICK     = 3'd1;
   localparam logic [2:0] OP_SEND     = 3'd2;
   localparam logic [2:0] OP_TX_SLOT  = 3'd3;
   localparam logic [2:0] OP_LINK_LOST = 3'd4;

   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_DISC = 2'd1;
   localparam logic [1:0] KIND_REQ  = 2'd2;
   localparam logic [1:0] KIND_DATA = 2'd3;

   localparam logic [2:0] FRAME_ACK     = 3'd0;
   localparam logic [2:0] FRAME_DISC    = 3'd1;
   localparam logic [2:0] FRAME_REQ     = 3'd2;
   localparam logic [2:0] FRAME_PAYLOAD = 3'd3;

   localparam logic [10:0] SUB_OLD_REQ = 11'd0;
   localparam logic [10:0] SUB_NEW_REQ = 11'd1;
   localparam logic [10:0] SUB_CONFIRM = 11'd4;

   localparam logic [2:0] CSR_BLOCK_ACTIVE = 3'd0;
   localparam logic [2:0] CSR_CONNECT_OK   = 3'd1;
   localparam logic [2:0] CSR_IDLE_TICKS   = 3'd2;
   localparam logic [2:0] CSR_RETRY_BASE   = 3'd3;
   localparam logic [2:0] CSR_RETRY_EXTRA  = 3'd4;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INACTIVE = 2'd1;
   localparam logic [1:0] STAT_NO_CONN = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   localparam logic [3:0] RETRIES_REQ  = 4'd4;
   localparam logic [3:0] RETRIES_DATA = 4'd8;
   localparam logic [10:0] SEQ_MOD_OLD = 11'd8;

   localparam logic [15:0] IDLE_TICKS_RST = 16'd6000;
   localparam logic [15:0] RETRY_BASE_RST = 16'd20;

endpackage

// File: design/link_connection_manager_core.sv
// Link connection manager core: top level, single module.
// Depends on lcm_pkg; holds the transmit window in two small synchronous memories.
//
// One transaction is taken when start is high and busy is low. Its result
// appears for one cycle on rsp_strobe, which the receiver cannot stall.
// Most transactions pass, after acceptance, through the execute, finish
// and result steps. A received ack while data awaits an ack walks the
// window through the memory read port, with a read state and a check
// state per slot. A transmit slot that sends data reads the memory once,
// through a read state and an output state. Busy stays high from
// acceptance until the result cycle begins, so the next transaction can
// be accepted at the edge that ends the result cycle.
module link_connection_manager_core #(
   parameter int WINDOW_NEW  = 5,
   parameter int SEQ_MOD_NEW = 2048,
   parameter int TAG_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_op,
   input  logic [2:0]          req_frame_type,
   input  logic [10:0]         req_frame_seq,
   input  logic                req_magic_present,
   input  logic [31:0]         req_frame_magic,
   input  logic [TAG_BITS-1:0] req_payload_tag,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   output logic                rsp_strobe,
   output logic                rsp_tx_valid,
   output logic [1:0]          rsp_tx_type,
   output logic [10:0]         rsp_tx_seq,
   output logic [31:0]         rsp_tx_magic,
   output logic [TAG_BITS-1:0] rsp_tx_tag,
   output logic                rsp_rx_valid,
   output logic [TAG_BITS-1:0] rsp_rx_tag,
   output logic                rsp_connected,
   output logic                rsp_new_style,
   output logic [2:0]          rsp_window_free,
   output logic [1:0]          rsp_status,
   output logic                rsp_baud_step
);

   localparam int WSLOTS = WINDOW_NEW + 1;
   localparam int PW     = $clog2(WSLOTS) < 1 ? 1 : $clog2(WSLOTS);
   localparam int SEQW   = $clog2(SEQ_MOD_NEW);
   localparam int WFW    = $clog2(WINDOW_NEW + 1) < 3 ? 3 : $clog2(WINDOW_NEW + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_REQ, ST_ACK, ST_DATA, ST_DATA_ACK
   } proto_type;

   typedef enum logic [2:0] {
      SQ_IDLE, SQ_EXEC, SQ_SCAN_RD, SQ_SCAN_CHK, SQ_TX_RD, SQ_TX_OUT, SQ_DONE
   } seq_type;

   // configuration
   logic        active_ff, conn_ok_ff;
   logic [15:0] idle_ticks_ff, retry_base_ff, retry_extra_ff;

   // protocol state
   proto_type   proto_ff;
   logic        peer_new_ff, link_up_ff, timer_run_ff, ctrl_pend_ff;
   logic [31:0] deadline_ff, tick_ff, magic_ff;
   logic [3:0]  retries_ff;
   logic [10:0] send_seq_ff, recv_seq_ff, ctrl_seq_ff;
   logic [1:0]  ctrl_kind_ff;
   logic [PW-1:0] head_ff, tail_ff, next_ff;

   // captured transaction
   logic [2:0]  op_ff, ftype_ff;
   logic [10:0] fseq_ff;
   logic        fmag_ok_ff;
   logic [31:0] fmagic_ff;
   logic [TAG_BITS-1:0] tag_ff;

   // scan state
   logic [PW-1:0] scan_p_ff;
   logic [PW:0]   scan_n_ff;
   logic          passed_ff;

   seq_type sq_ff;

   // window memories
   logic [10:0]         win_seq_mem [WSLOTS];
   logic [TAG_BITS-1:0] win_tag_mem [WSLOTS];
   logic [PW-1:0]       rd_addr;
   logic [10:0]         rd_seq_ff;
   logic [TAG_BITS-1:0] rd_tag_ff;
   logic                wr_en;
   logic [PW-1:0]       wr_addr;
   logic [10:0]         wr_seq;

   // result registers
   logic        o_strobe_ff, o_txv_ff, o_rxv_ff, o_baud_ff;
   logic [1:0]  o_txt_ff, o_stat_ff;
   logic [10:0] o_txs_ff;
   logic [31:0] o_txm_ff;
   logic [TAG_BITS-1:0] o_txtag_ff, o_rxtag_ff;

   function automatic logic [PW-1:0] win_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p == PW'(WSLOTS - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   function automatic logic [10:0] seq_inc(input logic [10:0] s, input logic nw);
      logic [11:0] t;
      logic [10:0] r;
      t = {1'b0, s} + 12'd1;
      if (nw) r = (t[10:0] == 11'(SEQ_MOD_NEW - 1) + 11'd1 || t == 12'(SEQ_MOD_NEW))
                  ? 11'd0 : t[10:0];
      else    r = (t[2:0] == 3'd0) ? 11'd0 : {8'd0, t[2:0]};
      if (nw && SEQW < 11) r = r & 11'((1 << SEQW) - 1);
      return r;
   endfunction

   function automatic logic [WFW-1:0] win_free(input logic up, input logic nw,
         input logic [PW-1:0] h, input logic [PW-1:0] t);
      logic [PW:0] used;
      logic [PW:0] cap;
      logic [WFW-1:0] r;
      used = (h >= t) ? {1'b0, h} - {1'b0, t} : {1'b0, h} + (PW+1)'(WSLOTS) - {1'b0, t};
      cap  = nw ? (PW+1)'(WINDOW_NEW) : (PW+1)'(1);
      if (!up || used >= cap) r = '0;
      else if (cap - used > 7) r = WFW'(7);
      else r = WFW'(cap - used);
      return r;
   endfunction

   assign busy = (sq_ff != SQ_IDLE);

   // window memory read address
   always_comb begin
      rd_addr = win_inc(next_ff);
      if (sq_ff == SQ_SCAN_RD || sq_ff == SQ_SCAN_CHK) rd_addr = win_inc(scan_p_ff);
   end

   // window memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_seq_mem[wr_addr] <= wr_seq;
         win_tag_mem[wr_addr] <= tag_ff;
      end
      rd_seq_ff <= win_seq_mem[rd_addr];
      rd_tag_ff <= win_tag_mem[rd_addr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         conn_ok_ff     <= 1'b0;
         idle_ticks_ff  <= lcm_pkg::IDLE_TICKS_RST;
         retry_base_ff  <= lcm_pkg::RETRY_BASE_RST;
         retry_extra_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lcm_pkg::CSR_BLOCK_ACTIVE: active_ff <= csr_data[0];
            lcm_pkg::CSR_CONNECT_OK:   conn_ok_ff <= csr_data[0];
            lcm_pkg::CSR_IDLE_TICKS:   idle_ticks_ff <= csr_data;
            lcm_pkg::CSR_RETRY_BASE:   retry_base_ff <= csr_data;
            lcm_pkg::CSR_RETRY_EXTRA:  retry_extra_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // next-state logic for the protocol engine
   proto_type   proto_in;
   logic        peer_new_in, link_up_in, timer_run_in, ctrl_pend_in;
   logic [31:0] deadline_in, tick_in, magic_in;
   logic [3:0]  retries_in;
   logic [10:0] send_seq_in, recv_seq_in, ctrl_seq_in;
   logic [1:0]  ctrl_kind_in;
   logic [PW-1:0] head_in, tail_in, next_in, scan_p_in;
   logic [PW:0]   scan_n_in;
   logic          passed_in;
   seq_type       sq_in;
   logic        o_strobe_in, o_txv_in, o_rxv_in, o_baud_in;
   logic [1:0]  o_txt_in, o_stat_in;
   logic [10:0] o_txs_in;
   logic [31:0] o_txm_in;
   logic [TAG_BITS-1:0] o_txtag_in, o_rxtag_in;
   logic [31:0] tick_nx, diff, retry_dl, idle_dl;
   logic        sub_ok, do_reset, do_queue, do_idle_t, do_retry_t;
   logic [1:0]  q_kind;
   logic [10:0] q_seq, nseq;
   logic [PW-1:0] p_nx;

   always_comb begin
      proto_in = proto_ff; peer_new_in = peer_new_ff; link_up_in = link_up_ff;
      timer_run_in = timer_run_ff; ctrl_pend_in = ctrl_pend_ff;
      deadline_in = deadline_ff; tick_in = tick_ff; magic_in = magic_ff;
      retries_in = retries_ff; send_seq_in = send_seq_ff; recv_seq_in = recv_seq_ff;
      ctrl_seq_in = ctrl_seq_ff; ctrl_kind_in = ctrl_kind_ff;
      head_in = head_ff; tail_in = tail_ff; next_in = next_ff;
      scan_p_in = scan_p_ff; scan_n_in = scan_n_ff; passed_in = passed_ff;
      sq_in = sq_ff;
      o_strobe_in = 1'b0; o_txv_in = o_txv_ff; o_rxv_in = o_rxv_ff; o_baud_in = o_baud_ff;
      o_txt_in = o_txt_ff; o_stat_in = o_stat_ff; o_txs_in = o_txs_ff;
      o_txm_in = o_txm_ff; o_txtag_in = o_txtag_ff; o_rxtag_in = o_rxtag_ff;
      wr_en = 1'b0; wr_addr = win_inc(head_ff); wr_seq = seq_inc(send_seq_ff, peer_new_ff);
      do_reset = 1'b0; do_queue = 1'b0; do_idle_t = 1'b0; do_retry_t = 1'b0;
      q_kind = lcm_pkg::KIND_ACK; q_seq = '0;
      tick_nx = tick_ff + 32'd1;
      diff = tick_nx - deadline_ff;
      nseq = seq_inc(recv_seq_ff, peer_new_ff);
      p_nx = win_inc(scan_p_ff);
      sub_ok = (fseq_ff == lcm_pkg::SUB_OLD_REQ) || (fseq_ff == lcm_pkg::SUB_NEW_REQ) ||
               (fseq_ff == lcm_pkg::SUB_CONFIRM);

      case (sq_ff)
         SQ_IDLE: begin
            if (start) sq_in = SQ_EXEC;
         end
         SQ_EXEC: begin
            o_txv_in = 1'b0; o_txt_in = '0; o_txs_in = '0; o_txm_in = '0;
            o_txtag_in = '0; o_rxv_in = 1'b0; o_rxtag_in = '0; o_baud_in = 1'b0;
            o_stat_in = lcm_pkg::STAT_OK;
            sq_in = SQ_DONE;
            if (!active_ff) begin
               o_stat_in = lcm_pkg::STAT_INACTIVE;
            end else begin
               case (op_ff)
                  lcm_pkg::OP_RX_FRAME: begin
                     case (ftype_ff)
                        lcm_pkg::FRAME_ACK: begin
                           if (proto_ff == ST_REQ || proto_ff == ST_ACK) begin
                              if (conn_ok_ff) begin
                                 send_seq_in = fseq_ff; recv_seq_in = '0;
                                 do_idle_t = 1'b1; proto_in = ST_DATA; link_up_in = 1'b1;
                              end
                           end else if (proto_ff == ST_DATA_ACK) begin
                              scan_p_in = tail_ff; scan_n_in = '0; passed_in = 1'b0;
                              sq_in = SQ_SCAN_RD;
                           end
                        end
                        lcm_pkg::FRAME_DISC: begin
                           if (proto_ff != ST_IDLE) do_reset = 1'b1;
                        end
                        lcm_pkg::FRAME_REQ: begin
                           if (sub_ok) begin
                              if (proto_ff == ST_DATA || proto_ff == ST_DATA_ACK) begin
                                 do_reset = 1'b1;
                              end else if (conn_ok_ff) begin
                                 if (fseq_ff == lcm_pkg::SUB_OLD_REQ && proto_ff != ST_IDLE
                                    || fseq_ff == lcm_pkg::SUB_CONFIRM && proto_ff == ST_ACK
                                       && fmag_ok_ff && fmagic_ff != magic_ff) begin
                                    peer_new_in = (fseq_ff == lcm_pkg::SUB_CONFIRM);
                                    send_seq_in = '0; recv_seq_in = '0;
                                    do_queue = 1'b1; do_idle_t = 1'b1;
                                    proto_in = ST_DATA; link_up_in = 1'b1;
                                 end else if (fseq_ff != lcm_pkg::SUB_CONFIRM) begin
                                    peer_new_in = (fseq_ff == lcm_pkg::SUB_NEW_REQ);
                                    do_queue = 1'b1; q_kind = lcm_pkg::KIND_REQ;
                                    q_seq = lcm_pkg::SUB_CONFIRM; do_retry_t = 1'b1;
                                    retries_in = lcm_pkg::RETRIES_REQ; proto_in = ST_ACK;
                                 end
                              end
                           end
                        end
                        lcm_pkg::FRAME_PAYLOAD: begin
                           if (proto_ff == ST_DATA || proto_ff == ST_DATA_ACK) begin
                              do_queue = 1'b1;
                              q_seq = recv_seq_ff;
                              if (fseq_ff == nseq) begin
                                 recv_seq_in = fseq_ff; q_seq = fseq_ff;
                                 o_rxv_in = 1'b1; o_rxtag_in = tag_ff;
                                 if (proto_ff == ST_DATA) do_idle_t = 1'b1;
                                 else do_retry_t = 1'b1;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
                  lcm_pkg::OP_TICK: begin
                     tick_in = tick_nx;
                     if (timer_run_ff && diff != 32'd0 && !diff[31]) begin
                        timer_run_in = 1'b0;
                        case (proto_ff)
                           ST_IDLE: begin
                              if (conn_ok_ff) begin
                                 do_queue = 1'b1; q_kind = lcm_pkg::KIND_REQ;
                                 q_seq = lcm_pkg::SUB_NEW_REQ; do_retry_t = 1'b1;
                                 proto_in = ST_REQ;
                              end
                           end
                           ST_REQ: begin
                              if (conn_ok_ff) begin
                                 o_baud_in = 1'b1;
                                 do_queue = 1'b1; q_kind = lcm_pkg::KIND_REQ;
                                 q_seq = lcm_pkg::SUB_NEW_REQ; do_retry_t = 1'b1;
                              end else do_reset = 1'b1;
                           end
                           ST_ACK: begin
                              if (conn_ok_ff) retries_in = retries_ff - 4'd1;
                              if (conn_ok_ff && retries_ff != 4'd1) begin
                                 do_queue = 1'b1; q_kind = lcm_pkg::KIND_REQ;
                                 q_seq = lcm_pkg::SUB_CONFIRM; do_retry_t = 1'b1;
                              end else do_reset = 1'b1;
                           end
                           ST_DATA: begin
                              do_queue = 1'b1; q_kind = lcm_pkg::KIND_DISC;
                              do_reset = 1'b1;
                           end
                           default: begin
                              retries_in = retries_ff - 4'd1;
                              if (retries_ff != 4'd1) begin
                                 next_in = tail_ff; do_retry_t = 1'b1;
                              end else begin
                                 do_queue = 1'b1; q_kind = lcm_pkg::KIND_DISC;
                                 do_reset = 1'b1;
                              end
                           end
                        endcase
                     end
                  end
                  lcm_pkg::OP_SEND: begin
                     if (!link_up_ff) o_stat_in = lcm_pkg::STAT_NO_CONN;
                     else if (win_free(link_up_ff, peer_new_ff, head_ff, tail_ff) == '0)
                        o_stat_in = lcm_pkg::STAT_FULL;
                     else begin
                        send_seq_in = wr_seq;
                        head_in = wr_addr;
                        wr_en = 1'b1;
                        do_retry_t = 1'b1;
                        retries_in = lcm_pkg::RETRIES_DATA;
                        proto_in = ST_DATA_ACK;
                     end
                  end
                  lcm_pkg::OP_TX_SLOT: begin
                     if (ctrl_pend_ff) begin
                        ctrl_pend_in = 1'b0;
                        o_txv_in = 1'b1; o_txt_in = ctrl_kind_ff; o_txs_in = ctrl_seq_ff;
                        if (ctrl_kind_ff == lcm_pkg::KIND_REQ && ctrl_seq_ff == lcm_pkg::SUB_CONFIRM)
                           o_txm_in = magic_ff;
                     end else if (next_ff != head_ff) begin
                        sq_in = SQ_TX_RD;
                     end
                  end
                  lcm_pkg::OP_LINK_LOST: begin
                     ctrl_pend_in = 1'b0;
                     do_reset = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         SQ_SCAN_RD: begin
            // memory read of slot after scan_p is in flight
            if (scan_p_ff == head_ff || scan_n_ff == (PW+1)'(WSLOTS)) begin
               sq_in = SQ_DONE;
               if (tail_ff == head_ff) begin proto_in = ST_DATA; do_idle_t = 1'b1; end
               else do_retry_t = 1'b1;
            end else sq_in = SQ_SCAN_CHK;
         end
         SQ_SCAN_CHK: begin
            if (scan_p_ff == next_ff) passed_in = 1'b1;
            if (fseq_ff == rd_seq_ff) begin
               tail_in = p_nx;
               if (scan_p_ff == next_ff || passed_ff) next_in = p_nx;
            end
            scan_p_in = p_nx;
            scan_n_in = scan_n_ff + 1'b1;
            sq_in = SQ_SCAN_RD;
         end
         SQ_TX_RD: begin
            sq_in = SQ_TX_OUT;
         end
         SQ_TX_OUT: begin
            next_in = win_inc(next_ff);
            o_txv_in = 1'b1; o_txt_in = lcm_pkg::KIND_DATA;
            o_txs_in = rd_seq_ff; o_txtag_in = rd_tag_ff;
            sq_in = SQ_DONE;
         end
         SQ_DONE: begin
            o_strobe_in = 1'b1;
            sq_in = SQ_IDLE;
         end
         default: sq_in = SQ_IDLE;
      endcase

      // shared actions
      if (do_queue) begin
         ctrl_kind_in = q_kind; ctrl_seq_in = q_seq; ctrl_pend_in = 1'b1;
      end
      idle_dl  = tick_in + {16'd0, idle_ticks_ff};
      retry_dl = tick_in + {16'd0, retry_base_ff} +
                 ((link_up_ff && !do_reset) || (do_reset && link_up_ff) ?
                  {16'd0, retry_extra_ff} : 32'd0);
      if (do_idle_t) begin deadline_in = idle_dl; timer_run_in = 1'b1; end
      if (do_retry_t) begin deadline_in = retry_dl; timer_run_in = 1'b1; end
      if (do_reset) begin
         proto_in = ST_IDLE; peer_new_in = 1'b0;
         deadline_in = retry_dl; timer_run_in = 1'b1;
         send_seq_in = '0; recv_seq_in = '0;
         head_in = '0; tail_in = '0; next_in = '0;
         magic_in = tick_in; link_up_in = 1'b0;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff <= SQ_IDLE;
         proto_ff <= ST_IDLE; peer_new_ff <= 1'b0; link_up_ff <= 1'b0;
         timer_run_ff <= 1'b1; ctrl_pend_ff <= 1'b0;
         deadline_ff <= {16'd0, lcm_pkg::RETRY_BASE_RST};
         tick_ff <= '0; magic_ff <= '0; retries_ff <= '0;
         send_seq_ff <= '0; recv_seq_ff <= '0; ctrl_seq_ff <= '0; ctrl_kind_ff <= '0;
         head_ff <= '0; tail_ff <= '0; next_ff <= '0;
         scan_p_ff <= '0; scan_n_ff <= '0; passed_ff <= 1'b0;
         o_strobe_ff <= 1'b0;
      end else begin
         sq_ff <= sq_in;
         proto_ff <= proto_in; peer_new_ff <= peer_new_in; link_up_ff <= link_up_in;
         timer_run_ff <= timer_run_in; ctrl_pend_ff <= ctrl_pend_in;
         deadline_ff <= deadline_in; tick_ff <= tick_in; magic_ff <= magic_in;
         retries_ff <= retries_in;
         send_seq_ff <= send_seq_in; recv_seq_ff <= recv_seq_in;
         ctrl_seq_ff <= ctrl_seq_in; ctrl_kind_ff <= ctrl_kind_in;
         head_ff <= head_in; tail_ff <= tail_in; next_ff <= next_in;
         scan_p_ff <= scan_p_in; scan_n_ff <= scan_n_in; passed_ff <= passed_in;
         o_strobe_ff <= o_strobe_in;
      end
   end

   // capture transaction and hold result payload
   always_ff @(posedge clock) begin
      if (sq_ff == SQ_IDLE && start) begin
         op_ff <= req_op; ftype_ff <= req_frame_type; fseq_ff <= req_frame_seq;
         fmag_ok_ff <= req_magic_present; fmagic_ff <= req_frame_magic;
         tag_ff <= req_payload_tag;
      end
      o_txv_ff <= o_txv_in; o_rxv_ff <= o_rxv_in; o_baud_ff <= o_baud_in;
      o_txt_ff <= o_txt_in; o_stat_ff <= o_stat_in; o_txs_ff <= o_txs_in;
      o_txm_ff <= o_txm_in; o_txtag_ff <= o_txtag_in; o_rxtag_ff <= o_rxtag_in;
   end

   logic [WFW-1:0] wf;
   assign wf = win_free(link_up_ff, peer_new_ff, head_ff, tail_ff);

   assign rsp_strobe      = o_strobe_ff;
   assign rsp_tx_valid    = o_txv_ff;
   assign rsp_tx_type     = o_txt_ff;
   assign rsp_tx_seq      = o_txs_ff;
   assign rsp_tx_magic    = o_txm_ff;
   assign rsp_tx_tag      = o_txtag_ff;
   assign rsp_rx_valid    = o_rxv_ff;
   assign rsp_rx_tag      = o_rxtag_ff;
   assign rsp_connected   = link_up_ff;
   assign rsp_new_style   = peer_new_ff;
   assign rsp_window_free = wf[2:0];
   assign rsp_status      = o_stat_ff;
   assign rsp_baud_step   = o_baud_ff;

endmodule
